// File: rtl/core/cursor_list_pool_with_set_ops_unit_defines.svh
// Assertion helper macros used by the bound assertion checker.
`ifndef CURSOR_LIST_POOL_WITH_SET_OPS_UNIT_DEFINES_SVH
`define CURSOR_LIST_POOL_WITH_SET_OPS_UNIT_DEFINES_SVH

// Assert a property on the rising clock edge, disabled in reset.
`define CLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert a property on the rising clock edge, active during reset too.
`define CLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/clp_pkg.sv
package clp_pkg;

  localparam int unsigned PoolDepth  = 32;
  localparam int unsigned NumLists   = 4;
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned PtrW       = 6;
  localparam logic [PtrW-1:0] EndMark = 6'd63;

  localparam logic [2:0] FuncInsFront = 3'd0;
  localparam logic [2:0] FuncInsTail  = 3'd1;
  localparam logic [2:0] FuncDelete   = 3'd2;
  localparam logic [2:0] FuncUnion    = 3'd3;
  localparam logic [2:0] FuncInter    = 3'd4;
  localparam logic [2:0] FuncDiff     = 3'd5;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  list_sel;
    logic [1:0]  list_a;
    logic [1:0]  list_b;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot;
    logic       slot_valid;
    logic [5:0] count;
  } rsp_t;

  // Node memory access command from the sequencer.
  typedef struct packed {
    logic            rd_en;
    logic [PtrW-1:0] rd_addr;
    logic            wv_en;
    logic [PtrW-1:0] wv_addr;
    logic [31:0]     wv_data;
    logic            wn_en;
    logic [PtrW-1:0] wn_addr;
    logic [PtrW-1:0] wn_data;
  } mem_cmd_t;

endpackage

// File: rtl/core/clp_node_mem.sv
module clp_node_mem #(
  parameter int unsigned POOL_DEPTH  = clp_pkg::PoolDepth,
  parameter int unsigned VALUE_WIDTH = clp_pkg::ValueWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  clp_pkg::mem_cmd_t          cmd_i,
  output logic [VALUE_WIDTH-1:0]     rd_value_o,
  output logic [clp_pkg::PtrW-1:0]   rd_next_o
);
  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  logic [VALUE_WIDTH-1:0]   value_mem [POOL_DEPTH];
  logic [clp_pkg::PtrW-1:0] next_mem  [POOL_DEPTH];
  logic [POOL_DEPTH-1:0]    vld_q;  // value written since reset
  logic [POOL_DEPTH-1:0]    nvld_q; // next written since reset
  logic                     rd_vv_q, rd_nv_q;
  logic [VALUE_WIDTH-1:0]   rd_val_q;
  logic [clp_pkg::PtrW-1:0] rd_nxt_q, rd_dflt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wv_en) begin
      value_mem[cmd_i.wv_addr[AW-1:0]] <= cmd_i.wv_data[VALUE_WIDTH-1:0];
    end
    if (cmd_i.wn_en) begin
      next_mem[cmd_i.wn_addr[AW-1:0]] <= cmd_i.wn_data;
    end
    if (cmd_i.rd_en) begin
      rd_val_q  <= value_mem[cmd_i.rd_addr[AW-1:0]];
      rd_nxt_q  <= next_mem[cmd_i.rd_addr[AW-1:0]];
      rd_dflt_q <= (32'(cmd_i.rd_addr) == POOL_DEPTH - 1) ? clp_pkg::EndMark
                   : clp_pkg::PtrW'(cmd_i.rd_addr + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      nvld_q  <= '0;
      rd_vv_q <= 1'b0;
      rd_nv_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rd_vv_q <= vld_q[cmd_i.rd_addr[AW-1:0]] ||
                   (cmd_i.wv_en && cmd_i.wv_addr == cmd_i.rd_addr && 1'b0);
        rd_nv_q <= nvld_q[cmd_i.rd_addr[AW-1:0]];
      end
      if (cmd_i.wv_en) vld_q[cmd_i.wv_addr[AW-1:0]] <= 1'b1;
      if (cmd_i.wn_en) nvld_q[cmd_i.wn_addr[AW-1:0]] <= 1'b1;
    end
  end

  assign rd_value_o = rd_vv_q ? rd_val_q : '0;
  assign rd_next_o  = rd_nv_q ? rd_nxt_q : rd_dflt_q;
endmodule

// File: rtl/core/clp_seq.sv
module clp_seq #(
  parameter int unsigned POOL_DEPTH  = clp_pkg::PoolDepth,
  parameter int unsigned NUM_LISTS   = clp_pkg::NumLists,
  parameter int unsigned VALUE_WIDTH = clp_pkg::ValueWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  clp_pkg::req_t            req_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output clp_pkg::rsp_t            rsp_o,
  output clp_pkg::mem_cmd_t        cmd_o,
  input  logic [VALUE_WIDTH-1:0]   rd_value_i,
  input  logic [clp_pkg::PtrW-1:0] rd_next_i
);
  localparam int unsigned PW = clp_pkg::PtrW;
  localparam int unsigned SW = $clog2(POOL_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TRD   = 9'b000000010, // insert: read free node n, then link
    S_TCHK  = 9'b000000100,
    S_DRD   = 9'b000001000, // delete walk
    S_DCHK  = 9'b000010000,
    S_SA    = 9'b000100000, // set op: read a
    S_SB    = 9'b001000000, // read b
    S_SC    = 9'b010000000, // read c, write result
    S_RSP   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [PW-1:0] head_q [NUM_LISTS];
  logic [PW-1:0] free_q;
  clp_pkg::req_t req_q;
  logic [PW-1:0] p_q, prev_q, a_q, b_q, n_q;
  logic [SW-1:0] steps_q;
  logic [VALUE_WIDTH-1:0] av_q, bv_q;
  clp_pkg::rsp_t rsp_q;
  logic [1:0] sub_q; // read-issue phase within a state

  function automatic logic is_node(logic [PW-1:0] p);
    return 32'(p) < POOL_DEPTH;
  endfunction

  logic sel_ok;
  assign sel_ok = 32'(req_i.list_sel) < NUM_LISTS;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RSP);
  assign rsp_o       = rsp_q;

  logic [VALUE_WIDTH-1:0] res_w;
  always_comb begin
    unique case (req_q.func)
      clp_pkg::FuncUnion: res_w = av_q | bv_q;
      clp_pkg::FuncInter: res_w = av_q & bv_q;
      default:            res_w = av_q & ~bv_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < NUM_LISTS; i++) head_q[i] <= clp_pkg::EndMark;
      free_q  <= '0;
      sub_q   <= '0;
      rsp_q   <= '0;
      req_q   <= '0;
      p_q <= '0; prev_q <= '0; a_q <= '0; b_q <= '0; n_q <= '0;
      steps_q <= '0; av_q <= '0; bv_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (req_valid_i) begin
          req_q <= req_i;
          rsp_q <= '0;
          steps_q <= '0;
          sub_q <= '0;
          if (req_i.func > clp_pkg::FuncDiff || !sel_ok) begin
            state_q <= S_RSP;
          end else if (req_i.func == clp_pkg::FuncInsFront ||
                       req_i.func == clp_pkg::FuncInsTail) begin
            if (!is_node(free_q)) begin
              rsp_q.status <= clp_pkg::StatusFull;
              state_q <= S_RSP;
            end else begin
              n_q <= free_q;
              p_q <= head_q[req_i.list_sel];
              state_q <= S_TRD; // first read free node's next
            end
          end else if (req_i.func == clp_pkg::FuncDelete) begin
            prev_q <= clp_pkg::EndMark;
            p_q <= head_q[req_i.list_sel];
            state_q <= S_DRD;
          end else begin
            a_q <= (32'(req_i.list_a) < NUM_LISTS) ? head_q[req_i.list_a] : clp_pkg::EndMark;
            b_q <= (32'(req_i.list_b) < NUM_LISTS) ? head_q[req_i.list_b] : clp_pkg::EndMark;
            p_q <= head_q[req_i.list_sel];
            state_q <= S_SA;
          end
        end
        // Insert: sub 0 issues read of n; sub 1 takes free next and links.
        S_TRD: begin
          if (sub_q == 2'd0) begin
            sub_q <= 2'd1;
          end else if (sub_q == 2'd1) begin
            free_q <= rd_next_i;
            rsp_q.slot <= n_q[4:0];
            rsp_q.slot_valid <= 1'b1;
            if (req_q.func == clp_pkg::FuncInsFront) begin
              head_q[req_q.list_sel] <= n_q;
              state_q <= S_RSP;
            end else if (!is_node(p_q)) begin
              head_q[req_q.list_sel] <= n_q;
              state_q <= S_RSP;
            end else begin
              steps_q <= SW'(1);
              sub_q <= 2'd2;
              state_q <= S_TCHK;
            end
          end
        end
        // Tail walk: sub 2 issues read of p; sub 3 checks next.
        S_TCHK: begin
          if (sub_q == 2'd2) begin
            sub_q <= 2'd3;
          end else begin
            if (is_node(rd_next_i) && 32'(steps_q) < POOL_DEPTH) begin
              p_q <= rd_next_i;
              steps_q <= steps_q + 1'b1;
              sub_q <= 2'd2;
            end else begin
              state_q <= S_RSP; // link written this cycle
            end
          end
        end
        S_DRD: begin
          if (!is_node(p_q) || 32'(steps_q) >= POOL_DEPTH) begin
            rsp_q.status <= clp_pkg::StatusNotFound;
            state_q <= S_RSP;
          end else begin
            state_q <= S_DCHK;
          end
        end
        // Delete: sub 0 compares and unlinks; sub 1 pushes the node on the free list.
        S_DCHK: begin
          if (sub_q == 2'd1) begin
            free_q <= p_q;
            state_q <= S_RSP;
          end else if (rd_value_i == req_q.value[VALUE_WIDTH-1:0]) begin
            if (!is_node(prev_q)) head_q[req_q.list_sel] <= rd_next_i;
            rsp_q.slot <= p_q[4:0];
            rsp_q.slot_valid <= 1'b1;
            sub_q <= 2'd1;
          end else begin
            prev_q <= p_q;
            p_q <= rd_next_i;
            steps_q <= steps_q + 1'b1;
            state_q <= S_DRD;
          end
        end
        S_SA: begin
          if (!is_node(p_q) || 32'(steps_q) >= POOL_DEPTH) begin
            rsp_q.count <= 6'(steps_q);
            state_q <= S_RSP;
          end else begin
            state_q <= S_SB; // read of a issued
          end
        end
        S_SB: begin
          av_q <= is_node(a_q) ? rd_value_i : '0;
          if (is_node(a_q)) a_q <= rd_next_i;
          state_q <= S_SC;
        end
        S_SC: begin
          if (sub_q == 2'd0) begin
            bv_q <= is_node(b_q) ? rd_value_i : '0;
            if (is_node(b_q)) b_q <= rd_next_i;
            sub_q <= 2'd1;
          end else begin
            p_q <= rd_next_i;
            steps_q <= steps_q + 1'b1;
            sub_q <= 2'd0;
            state_q <= S_SA;
          end
        end
        S_RSP: if (rsp_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Memory commands: one port read per cycle, writes alongside.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_TRD: begin
        if (sub_q == 2'd0) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = n_q;
        end else if (sub_q == 2'd1) begin
          cmd_o.wv_en = 1'b1;
          cmd_o.wv_addr = n_q;
          cmd_o.wv_data = 32'(req_q.value[VALUE_WIDTH-1:0]);
          cmd_o.wn_en = 1'b1;
          cmd_o.wn_addr = n_q;
          cmd_o.wn_data = (req_q.func == clp_pkg::FuncInsFront) ?
                          head_q[req_q.list_sel] : clp_pkg::EndMark;
        end
      end
      S_TCHK: begin
        if (sub_q == 2'd2) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = p_q;
        end else if (!(is_node(rd_next_i) && 32'(steps_q) < POOL_DEPTH)) begin
          cmd_o.wn_en = 1'b1;
          cmd_o.wn_addr = p_q;
          cmd_o.wn_data = n_q;
        end
      end
      S_DRD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_addr = p_q;
      end
      S_DCHK: begin
        if (sub_q == 2'd1) begin
          cmd_o.wn_en = 1'b1;
          cmd_o.wn_addr = p_q;
          cmd_o.wn_data = free_q;
        end else if (rd_value_i == req_q.value[VALUE_WIDTH-1:0] && is_node(prev_q)) begin
          cmd_o.wn_en = 1'b1;
          cmd_o.wn_addr = prev_q;
          cmd_o.wn_data = rd_next_i;
        end
      end
      S_SA: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_addr = a_q;
      end
      S_SB: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_addr = b_q;
      end
      S_SC: begin
        if (sub_q == 2'd0) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = p_q;
        end else begin
          cmd_o.wv_en = 1'b1;
          cmd_o.wv_addr = p_q;
          cmd_o.wv_data = 32'(res_w);
        end
      end
      default: cmd_o = '0;
    endcase
  end
endmodule

// File: rtl/core/cursor_list_pool_with_set_ops_unit.sv
// cursor_list_pool_with_set_ops_unit
//
// A pool of POOL_DEPTH nodes holding NUM_LISTS singly linked lists and a
// free list. One request item (func, list_sel, list_a, list_b, value) enters
// on req_valid_i/req_ready_o; exactly one response item (status, slot,
// slot_valid, count) leaves on rsp_valid_o/rsp_ready_i.
// A sequencer drives one shared single-read node memory, one read per cycle
// with writes alongside: insert reads the free node's next, then writes and
// links the node (tail after a walk to the last node); delete reads each node
// and pushes a match on the free list; set ops read a, b, target, then write.
// Only one item is in flight: req_ready_o is high only while idle.
// When the receiver stalls, the response is held in its register and no
// new item is taken until it is accepted.
// Reset empties every list and chains all nodes onto the free list; node
// contents read as reset values through per-entry written flags.
module cursor_list_pool_with_set_ops_unit #(
  parameter int unsigned POOL_DEPTH  = clp_pkg::PoolDepth,
  parameter int unsigned NUM_LISTS   = clp_pkg::NumLists,
  parameter int unsigned VALUE_WIDTH = clp_pkg::ValueWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  clp_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output clp_pkg::rsp_t rsp_o
);
  clp_pkg::mem_cmd_t        cmd;
  logic [VALUE_WIDTH-1:0]   rd_value;
  logic [clp_pkg::PtrW-1:0] rd_next;

  clp_seq #(.POOL_DEPTH(POOL_DEPTH), .NUM_LISTS(NUM_LISTS), .VALUE_WIDTH(VALUE_WIDTH))
  u_seq (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o,
    .cmd_o(cmd), .rd_value_i(rd_value), .rd_next_i(rd_next)
  );

  clp_node_mem #(.POOL_DEPTH(POOL_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
    .clk_i, .rst_ni, .cmd_i(cmd), .rd_value_o(rd_value), .rd_next_o(rd_next)
  );
endmodule

// File: rtl/core/clp_checker.sv
`include "cursor_list_pool_with_set_ops_unit_defines.svh"
module clp_assert_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_o,
  input logic          rsp_valid_o,
  input logic          rsp_ready_i,
  input clp_pkg::rsp_t rsp_o
);
  `CLP_ASSERT(a_one_in_flight, (req_ready_o |-> !rsp_valid_o), "ready while response pending")
  `CLP_ASSERT(a_rsp_hold, ((rsp_valid_o && !rsp_ready_i) |=> (rsp_valid_o && $stable(rsp_o))), "response changed while stalled")
  `CLP_ASSERT(a_slot_zero, ((rsp_valid_o && !rsp_o.slot_valid) |-> (rsp_o.slot == '0)), "slot set without slot_valid")
  `CLP_ASSERT(a_accept_busy, ((req_valid_i && req_ready_o) |=> !req_ready_o), "ready right after accept")
  `CLP_ASSERT_ALWAYS(a_reset_idle, (!rst_ni |-> !rsp_valid_o), "response during reset")
endmodule

bind cursor_list_pool_with_set_ops_unit clp_assert_checker u_clp_checker (.*);

// File: verif/clp_checker.sv
`timescale 1ns / 100ps
module clp_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  clp_pkg::req_t req_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  clp_pkg::rsp_t rsp_i,
  output int unsigned   fail_cnt_o,
  output int unsigned   pending_o,
  output int unsigned   rsp_cnt_o
);
  import clp_pkg::*;

  logic [PtrW-1:0]       head_q [NumLists];
  logic [ValueWidth-1:0] val_q  [PoolDepth];
  logic [PtrW-1:0]       next_q [PoolDepth];
  logic [PtrW-1:0]       free_q;
  rsp_t                  expected_rsps [$];

  function automatic bit is_node(logic [PtrW-1:0] p);
    return p < PoolDepth;
  endfunction

  function automatic rsp_t apply_op(req_t r);
    rsp_t o;
    logic [PtrW-1:0] n, p, prev, a, b, c;
    logic [ValueWidth-1:0] av, bv;
    int steps;
    o = '0;
    if (r.func > FuncDiff || r.list_sel >= NumLists) return o;
    if (r.func == FuncInsFront || r.func == FuncInsTail) begin
      n = free_q;
      if (!is_node(n)) begin
        o.status = StatusFull;
        return o;
      end
      free_q = next_q[n];
      val_q[n] = r.value;
      if (r.func == FuncInsFront) begin
        next_q[n] = head_q[r.list_sel];
        head_q[r.list_sel] = n;
      end else begin
        next_q[n] = EndMark;
        p = head_q[r.list_sel];
        if (!is_node(p)) begin
          head_q[r.list_sel] = n;
        end else begin
          steps = 1;
          while (is_node(next_q[p]) && steps < PoolDepth) begin
            p = next_q[p];
            steps++;
          end
          next_q[p] = n;
        end
      end
      o.slot = n[4:0];
      o.slot_valid = 1'b1;
      return o;
    end
    if (r.func == FuncDelete) begin
      prev = EndMark;
      p = head_q[r.list_sel];
      steps = 0;
      while (is_node(p) && steps < PoolDepth && val_q[p] != r.value) begin
        prev = p;
        p = next_q[p];
        steps++;
      end
      if (!is_node(p) || steps >= PoolDepth) begin
        o.status = StatusNotFound;
        return o;
      end
      if (is_node(prev)) next_q[prev] = next_q[p];
      else head_q[r.list_sel] = next_q[p];
      next_q[p] = free_q;
      free_q = p;
      o.slot = p[4:0];
      o.slot_valid = 1'b1;
      return o;
    end
    a = (r.list_a < NumLists) ? head_q[r.list_a] : EndMark;
    b = (r.list_b < NumLists) ? head_q[r.list_b] : EndMark;
    c = head_q[r.list_sel];
    steps = 0;
    while (is_node(c) && steps < PoolDepth) begin
      av = is_node(a) ? val_q[a] : '0;
      bv = is_node(b) ? val_q[b] : '0;
      case (r.func)
        FuncUnion: val_q[c] = av | bv;
        FuncInter: val_q[c] = av & bv;
        default:   val_q[c] = av & ~bv;
      endcase
      if (is_node(a)) a = next_q[a];
      if (is_node(b)) b = next_q[b];
      c = next_q[c];
      steps++;
    end
    o.count = steps[5:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    rsp_cnt_o = 0;
    for (int i = 0; i < NumLists; i++) head_q[i] = EndMark;
    for (int i = 0; i < PoolDepth; i++) begin
      val_q[i] = '0;
      next_q[i] = (i == PoolDepth - 1) ? EndMark : PtrW'(i + 1);
    end
    free_q = '0;
  end

  assign pending_o = expected_rsps.size();

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      // Compare the response first; a new item cannot complete in the same cycle.
      if (rsp_valid_i && rsp_ready_i) begin
        rsp_cnt_o++;
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", 1, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.status != want.status) report_mismatch("status", rsp_i.status, want.status);
          if (rsp_i.slot != want.slot) report_mismatch("slot", rsp_i.slot, want.slot);
          if (rsp_i.slot_valid != want.slot_valid)
            report_mismatch("slot_valid", rsp_i.slot_valid, want.slot_valid);
          if (rsp_i.count != want.count) report_mismatch("count", rsp_i.count, want.count);
        end
      end
      if (req_valid_i && req_ready_i) expected_rsps.push_back(apply_op(req_i));
    end
  end
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import clp_pkg::*;

  logic          clk_i, rst_ni;
  logic          req_valid_i, req_ready_o, rsp_valid_o, rsp_ready_i;
  req_t          req_i;
  rsp_t          rsp_o;
  int unsigned   fail_cnt, pending, rsp_cnt;
  int unsigned   quiet_cycles;
  int unsigned   sent;
  bit            tail_calm;  // last part of the run: no idling
  bit            long_hold;  // receiver holds off for a long stretch

  localparam int unsigned WatchdogLimit = 20000;

  cursor_list_pool_with_set_ops_unit dut (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  clp_checker chk (
    .clk_i, .rst_ni,
    .req_valid_i, .req_ready_i(req_ready_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_ready_i, .rsp_i(rsp_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .rsp_cnt_o(rsp_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Send one item: hold valid and payload until the handshake. Valid drops
  // only for an idle burst or a drain, so back-to-back items never assign it
  // twice in one time step.
  task automatic send_item(logic [2:0] f, logic [1:0] sel, logic [1:0] la,
                           logic [1:0] lb, logic [15:0] v);
    int gap;
    if (!tail_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= '{func: f, list_sel: sel, list_a: la, list_b: lb, value: v};
    do @(posedge clk_i); while (!req_ready_o);
    sent++;
  endtask

  // Random item, mostly inserts and deletes of mostly small values so
  // that deletes hit and the pool swings between empty and full.
  task automatic send_random;
    logic [2:0] f;
    logic [15:0] v;
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) f = FuncInsFront;
    else if (k < 45) f = FuncInsTail;
    else if (k < 75) f = FuncDelete;
    else if (k < 83) f = FuncUnion;
    else if (k < 90) f = FuncInter;
    else if (k < 97) f = FuncDiff;
    else f = 3'($urandom_range(6, 7));
    v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    send_item(f, 2'($urandom), 2'($urandom), 2'($urandom), v);
  endtask

  task automatic drain;
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int gap;
    rsp_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        rsp_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!tail_calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 17);
        rsp_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        rsp_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout after %0d idle cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    sent = 0;
    tail_calm = 1'b0;
    long_hold = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list cases, extreme values, every operation.
    send_item(FuncDelete, 2'd0, 2'd0, 2'd0, 16'h0000);      // delete from empty list
    send_item(FuncUnion, 2'd0, 2'd1, 2'd2, 16'h0000);       // set op on empty target
    send_item(FuncInsFront, 2'd0, 2'd0, 2'd0, 16'hFFFF);
    send_item(FuncInsTail, 2'd0, 2'd0, 2'd0, 16'h0000);
    send_item(FuncInsTail, 2'd0, 2'd0, 2'd0, 16'hA5A5);
    send_item(FuncInsFront, 2'd1, 2'd0, 2'd0, 16'h5A5A);
    send_item(FuncInsTail, 2'd2, 2'd0, 2'd0, 16'h1234);
    // Operand shorter than target, and operand list empty.
    send_item(FuncUnion, 2'd2, 2'd0, 2'd1, 16'h0000);
    send_item(FuncInter, 2'd0, 2'd0, 2'd1, 16'h0000);
    send_item(FuncDiff, 2'd0, 2'd0, 2'd3, 16'hFFFF);
    send_item(FuncDiff, 2'd3, 2'd0, 2'd1, 16'h0000);
    send_item(3'd6, 2'd0, 2'd0, 2'd0, 16'hFFFF);            // unknown func
    send_item(3'd7, 2'd3, 2'd3, 2'd3, 16'h0000);
    send_item(FuncDelete, 2'd0, 2'd0, 2'd0, 16'hBEEF);      // value absent
    send_item(FuncDelete, 2'd0, 2'd0, 2'd0, 16'h0000);      // middle node
    send_item(FuncDelete, 2'd1, 2'd0, 2'd0, 16'h5A5A);      // freed node goes on free head
    send_item(FuncInsFront, 2'd3, 2'd0, 2'd0, 16'h7777);    // reuses that node
    // Fill the pool to overflow (tail walks get long), then free it again.
    for (int i = 0; i < 32; i++) send_item(FuncInsTail, 2'd1, 2'd0, 2'd0, 16'(i));
    send_item(FuncInsFront, 2'd2, 2'd0, 2'd0, 16'hFFFF);
    send_item(FuncUnion, 2'd1, 2'd0, 2'd3, 16'h0000);
    drain();

    // Sender keeps offering while the receiver holds off.
    long_hold = 1'b1;
    for (int i = 0; i < 10; i++) send_random();
    drain();

    while (sent < 420) send_random();
    drain();
    tail_calm = 1'b1;
    while (sent < 500) send_random();
    drain();
    repeat (200) @(posedge clk_i);

    $display("Ran %0d items, %0d responses checked: inserts to pool full, deletes hit and miss,",
             sent, rsp_cnt);
    $display("union, intersection and difference with short and missing operand lists.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
